FILE: hdl/bcu_pkg.sv
// ---------------------------------------------------------------------------
// bcu_pkg
// Shared widths, limits and controller/datapath interface types for the
// binomial coefficient unit.
// ---------------------------------------------------------------------------
package bcu_pkg;

    // field widths
    localparam int N_W    = 6;
    localparam int COEF_W = 59;

    // largest set size that still gives a coefficient that fits
    localparam logic [N_W-1:0] MAX_N = N_W'(62);

    // running product times one numerator term
    localparam int PROD_W = COEF_W + N_W;
    localparam int CNT_W  = $clog2(PROD_W);
    // remainder of the long division, one bit above the divisor
    localparam int REM_W  = N_W + 1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new pair, set up count and accumulator
        logic mul;        // form acc * (n - i) into the division register
        logic div_step;   // one restoring division step
        logic update;     // take the quotient as new accumulator, advance i
        logic emit;       // move the accumulator to the output register
    } bcu_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic steps_done; // every multiply-divide step has been done
        logic div_last;   // current division step is the last one
        logic out_free;   // output register can take a new result
    } bcu_sts_t;

endpackage

FILE: hdl/bcu_ctrl.sv
// ---------------------------------------------------------------------------
// bcu_ctrl
// Sequencer for the binomial coefficient unit: one multiply, then a
// bit-serial exact division, for each step of the product.
// ---------------------------------------------------------------------------
module bcu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bcu_pkg::bcu_sts_t sts,
    output bcu_pkg::bcu_cmd_t cmd
);
    import bcu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.steps_done ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.emit     = (state_reg == ST_DONE) && sts.out_free;
    end

    // only a new pair is taken while idle
    assign in_stall = (state_reg != ST_IDLE);

    // a result leaves only when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register busy");

    // each division runs to its last step before the update
    a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $past(state_reg == ST_DIV) && $past(sts.div_last))
        else $error("update without completed division");

    // after the last step the result is emitted or held
    a_check_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) && sts.steps_done |=> (state_reg == ST_DONE))
        else $error("finished product not handed to output");

endmodule

FILE: hdl/bcu_dp.sv
// ---------------------------------------------------------------------------
// bcu_dp
// Datapath of the binomial coefficient unit: accumulator, step counter,
// narrow multiplier, restoring divider and output register.
// ---------------------------------------------------------------------------
module bcu_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bcu_pkg::N_W-1:0]    total_n,
    input  logic [bcu_pkg::N_W-1:0]    choose_r,
    output logic [bcu_pkg::COEF_W-1:0] coefficient,
    output logic                      out_valid,
    input  logic                      out_stall,
    input  bcu_pkg::bcu_cmd_t          cmd,
    output bcu_pkg::bcu_sts_t          sts
);
    import bcu_pkg::*;

    logic [N_W-1:0]    n_reg;
    logic [N_W-1:0]    r_reg;
    logic [N_W-1:0]    i_reg;
    logic [COEF_W-1:0] acc_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [COEF_W-1:0] coef_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              zero_case;
    logic [N_W-1:0]    n_minus_r;
    logic [N_W-1:0]    r_eff;
    logic [N_W-1:0]    num_term;
    logic [N_W-1:0]    den_term;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  rem_shift;
    logic              rem_ge;
    logic [REM_W-1:0]  rem_new;

    // range check and symmetric choice count
    assign zero_case = (total_n > MAX_N) || (choose_r > total_n);
    assign n_minus_r = total_n - choose_r;
    assign r_eff     = (n_minus_r < choose_r) ? n_minus_r : choose_r;

    // step terms: numerator n - i, divisor i + 1
    assign num_term = n_reg - i_reg;
    assign den_term = i_reg + N_W'(1);
    assign prod     = PROD_W'(acc_reg) * PROD_W'(num_term);

    // one restoring division step, quotient bits shift in from the right
    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[PROD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_term});
    assign rem_new   = rem_ge ? (rem_shift - {1'b0, den_term}) : rem_shift;

    // operand and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= total_n;
            r_reg   <= zero_case ? '0 : r_eff;
            i_reg   <= '0;
            acc_reg <= zero_case ? '0 : COEF_W'(1);
        end
        else if (cmd.update)
        begin
            acc_reg <= quo_reg[COEF_W-1:0];
            i_reg   <= i_reg + N_W'(1);
        end

        if (cmd.mul)
        begin
            quo_reg <= prod;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], rem_ge};
            rem_reg <= rem_new;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end

        if (cmd.emit)
        begin
            coef_reg <= acc_reg;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // status to the controller
    always_comb
    begin
        sts            = '0;
        sts.steps_done = (i_reg == r_reg);
        sts.div_last   = (cnt_reg == CNT_W'(PROD_W - 1));
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign coefficient = coef_reg;
    assign out_valid   = out_valid_reg;

    // every step divides exactly
    a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (rem_reg == '0))
        else $error("division left a remainder");

    // the quotient always fits the accumulator
    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (quo_reg[PROD_W-1:COEF_W] == '0))
        else $error("quotient overflows accumulator");

    // a result is emitted only once all steps are done
    a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (i_reg == r_reg))
        else $error("result emitted before last step");

endmodule

FILE: hdl/binomial_coefficient_unit.sv
// ---------------------------------------------------------------------------
// binomial_coefficient_unit
// Exact binomial coefficient C(total_n, choose_r) by repeated multiply and
// exact division, zero when choose_r exceeds total_n or total_n exceeds 62.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (total_n, choose_r, in_valid, in_stall): a pair transfers
//   at a clock edge with in_valid high and in_stall low. in_stall is high
//   while a pair is being worked on, so one pair is in the unit at a time.
//   Output channel (coefficient, out_valid, out_stall): one result per pair,
//   held in an output register until it transfers with out_stall low.
//   With r = min(choose_r, total_n - choose_r), the unit runs r steps, each
//   a multiply, a bit-serial division of the 65-bit product by the step's
//   divisor, an update and a check; out-of-range pairs and r = 0 run no
//   steps. The serial divider sets the rate.
//   A new pair is taken as soon as the previous result sits in the output
//   register, even if the receiver still stalls it; a finished result then
//   waits in the unit until the output register frees up.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   out_valid; no other state needs clearing.
// ---------------------------------------------------------------------------
module binomial_coefficient_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bcu_pkg::N_W-1:0]    total_n,
    input  logic [bcu_pkg::N_W-1:0]    choose_r,
    input  logic                      in_valid,
    output logic                      in_stall,
    output logic [bcu_pkg::COEF_W-1:0] coefficient,
    output logic                      out_valid,
    input  logic                      out_stall
);
    import bcu_pkg::*;

    bcu_cmd_t cmd;
    bcu_sts_t sts;

    // sequencer
    bcu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and output register
    bcu_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .total_n     (total_n),
        .choose_r    (choose_r),
        .coefficient (coefficient),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

FILE: tb/binomial_coefficient_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// binomial_coefficient_unit_tb
// Drives (total_n, choose_r) pairs through the unit with random idle bursts
// on both channels and checks every coefficient against an exact wide
// arithmetic computation of C(n, r), in order of transfer.
// ---------------------------------------------------------------------------
module binomial_coefficient_unit_tb;

    import bcu_pkg::*;

    localparam int RANDOM_PAIRS = 250;
    localparam int CALM_PAIRS   = 40;

    // expected coefficients in transfer order, with an exact predictor
    class coeff_scoreboard;
        logic [COEF_W-1:0] coeff_q[$];
        int                mismatches;

        function new();
            mismatches = 0;
        endfunction

        // C(n, r) built up as C(n, i+1) = C(n, i) * (n - i) / (i + 1)
        function logic [COEF_W-1:0] calc_coefficient(logic [N_W-1:0] n,
                                                      logic [N_W-1:0] r);
            logic [71:0]    prod;
            logic [N_W-1:0] k;
            int             i;
            if (n > MAX_N || r > n)
                return '0;
            k    = (n - r < r) ? n - r : r;
            prod = 72'd1;
            for (i = 0; i < k; i++)
                prod = (prod * 72'(n - i)) / 72'(i + 1);
            return prod[COEF_W-1:0];
        endfunction

        function void note_pair(logic [N_W-1:0] n, logic [N_W-1:0] r);
            coeff_q.insert(coeff_q.size(), calc_coefficient(n, r));
        endfunction

        function void check_result(logic [COEF_W-1:0] got);
            logic [COEF_W-1:0] want;
            if (coeff_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected coefficient %0d", $realtime, got);
                return;
            end
            want = coeff_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: coefficient mismatch, expected %0d, got %0d",
                             $realtime, want, got);
            end
        endfunction

        function int pending();
            return coeff_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic [N_W-1:0]       total_n;
    logic [N_W-1:0]       choose_r;
    logic                 in_valid;
    logic                 in_stall;
    logic [COEF_W-1:0]    coefficient;
    logic                 out_valid;
    logic                 out_stall;

    coeff_scoreboard      sb;
    bit                   idle_on;
    int                   stall_left;

    // edge cases: empty choice, full set, middle, out-of-range set and choice
    logic [N_W-1:0] dir_n [0:21] = '{6'd0,  6'd0,  6'd62, 6'd62, 6'd62, 6'd62,
                                     6'd62, 6'd62, 6'd63, 6'd63, 6'd63, 6'd5,
                                     6'd1,  6'd1,  6'd61, 6'd40, 6'd10, 6'd7,
                                     6'd2,  6'd62, 6'd42, 6'd21};
    logic [N_W-1:0] dir_r [0:21] = '{6'd0,  6'd63, 6'd31, 6'd0,  6'd62, 6'd1,
                                     6'd61, 6'd30, 6'd0,  6'd31, 6'd63, 6'd6,
                                     6'd1,  6'd0,  6'd30, 6'd20, 6'd5,  6'd3,
                                     6'd1,  6'd63, 6'd21, 6'd42};

    binomial_coefficient_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .total_n     (total_n),
        .choose_r    (choose_r),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coefficient (coefficient),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // present one pair, possibly after an idle burst, and wait for its transfer
    task automatic send_pair(input logic [N_W-1:0] n, input logic [N_W-1:0] r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        total_n  <= n;
        choose_r <= r;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_pair(n, r);
    endtask

    // hold off the input until every coefficient has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // mostly well-formed pairs, a share of raw 6-bit noise
    task automatic random_pair(output logic [N_W-1:0] n, output logic [N_W-1:0] r);
        int nn;
        int k;
        if ($urandom_range(0, 9) < 7)
        begin
            nn = $urandom_range(0, 62);
            if ($urandom_range(0, 1) == 1)
            begin
                // short step count, from either side of the symmetry
                k = $urandom_range(0, (nn > 6) ? 6 : nn);
                r = N_W'(($urandom_range(0, 1) == 1) ? k : nn - k);
            end
            else
                r = N_W'($urandom_range(0, nn));
            n = N_W'(nn);
        end
        else
        begin
            n = N_W'($urandom);
            r = N_W'($urandom);
        end
    endtask

    // receiver: check transfers, stall in random bursts
    initial
    begin
        stall_left = 0;
        out_stall  <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(coefficient);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 9);
                out_stall <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [N_W-1:0] n;
        logic [N_W-1:0] r;
        int             idx;
        sb         = new();
        idle_on    = 1'b1;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        total_n    <= '0;
        choose_r   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs
        for (idx = 0; idx < 22; idx++)
            send_pair(dir_n[idx], dir_r[idx]);
        drain_results();

        // random pairs, quiet at the end
        for (idx = 0; idx < RANDOM_PAIRS; idx++)
        begin
            if (idx == RANDOM_PAIRS / 2)
                drain_results();
            if (idx == RANDOM_PAIRS - CALM_PAIRS)
                idle_on = 1'b0;
            random_pair(n, r);
            send_pair(n, r);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bcu_pkg.sv
hdl/bcu_ctrl.sv
hdl/bcu_dp.sv
hdl/binomial_coefficient_unit.sv
tb/binomial_coefficient_unit_tb.sv
